// File: design/fbpa_pkg.sv
// Shared constants and types for the fixed block pool allocator.
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int WORD_BITS = 32;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_MEM       = 3'd1;
  localparam logic [2:0] ST_OUT_OF_POOL  = 3'd2;
  localparam logic [2:0] ST_UNALIGNED    = 3'd3;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

  typedef struct packed {
    logic rd;
    logic wr;
    logic init;
  } map_ctl_t;

endpackage

// File: design/fixed_block_pool_allocator_core.sv
// Top level of the fixed block pool allocator.
// A request accepted in idle is evaluated in the EVAL state; done and the result are registered from it.
// No new request is accepted while busy; busy covers the free map read-modify-write.
// Reset clears pool_base and marks every block in use; init needs no clearing pass.
// The receiver cannot stall: done lasts exactly one cycle.
`timescale 1ns / 1ps

module fixed_block_pool_allocator_core #(
  parameter int BLOCK_COUNT = 64,
  parameter int BLOCK_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [31:0] address,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] block_address
);

  localparam int WB      = fbpa_pkg::WORD_BITS;
  localparam int ROWS    = (BLOCK_COUNT + WB - 1) / WB;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BIT_W   = $clog2(WB);
  localparam int FIDX_W  = ROW_W + BIT_W;
  localparam int BYTE_SH = $clog2(BLOCK_BYTES);
  localparam logic [32:0] SPAN = 33'(BLOCK_COUNT * BLOCK_BYTES);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic        state;
  logic        state_next;
  logic [31:0] pool_base;
  logic [32:0] pool_end;

  logic [1:0]       op_mode;
  logic [2:0]       op_status;
  logic [ROW_W-1:0] op_row;
  logic [BIT_W-1:0] op_bit;

  logic              accept;
  logic [31:0]       offset;
  logic              out_of_pool;
  logic              unaligned;
  logic [FIDX_W-1:0] free_idx;
  logic [ROW_W-1:0]  alloc_row;
  logic [ROW_W-1:0]  rd_row;
  logic [2:0]        pre_status;

  fbpa_pkg::map_ctl_t ctl;
  logic [WB-1:0]      rd_word;
  logic [WB-1:0]      wr_word;
  logic [ROWS-1:0]    row_nonempty;

  logic [BIT_W-1:0]  low_bit;
  logic [FIDX_W-1:0] alloc_idx;
  logic [2:0]        status_next;
  logic [31:0]       block_address_next;

  assign busy   = (state == S_EVAL);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_end  <= SPAN;
    end else if (cfg_write) begin
      pool_base <= cfg_data;
      pool_end  <= {1'b0, cfg_data} + SPAN;
    end
  end

  assign offset      = address - pool_base;
  assign out_of_pool = (address < pool_base) || ({1'b0, address} >= pool_end);
  assign unaligned   = |offset[BYTE_SH-1:0];
  assign free_idx    = offset[BYTE_SH +: FIDX_W];

  always_comb begin
    alloc_row = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (row_nonempty[r]) begin
        alloc_row = ROW_W'(r);
      end
    end
  end

  always_comb begin
    pre_status = fbpa_pkg::ST_OK;
    rd_row     = alloc_row;
    if (mode == fbpa_pkg::MODE_FREE) begin
      rd_row = free_idx[FIDX_W-1:BIT_W];
      if (out_of_pool) begin
        pre_status = fbpa_pkg::ST_OUT_OF_POOL;
      end else if (unaligned) begin
        pre_status = fbpa_pkg::ST_UNALIGNED;
      end
    end else if (mode == fbpa_pkg::MODE_ALLOC) begin
      if (!(|row_nonempty)) begin
        pre_status = fbpa_pkg::ST_NO_MEM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode   <= mode;
      op_status <= pre_status;
      op_row    <= rd_row;
      op_bit    <= free_idx[BIT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    low_bit = '0;
    for (int j = WB - 1; j >= 0; j--) begin
      if (rd_word[j]) begin
        low_bit = BIT_W'(j);
      end
    end
  end

  assign alloc_idx = {op_row, low_bit};

  always_comb begin
    ctl                = '0;
    ctl.rd             = accept;
    wr_word            = rd_word;
    status_next        = op_status;
    block_address_next = '0;
    if (busy) begin
      case (op_mode)
        fbpa_pkg::MODE_ALLOC: begin
          if (op_status == fbpa_pkg::ST_OK) begin
            wr_word            = rd_word & ~(WB'(1) << low_bit);
            ctl.wr             = 1'b1;
            block_address_next = pool_base + (32'(alloc_idx) << BYTE_SH);
          end
        end
        fbpa_pkg::MODE_FREE: begin
          if (op_status == fbpa_pkg::ST_OK) begin
            if (rd_word[op_bit]) begin
              status_next = fbpa_pkg::ST_ALREADY_FREE;
            end else begin
              wr_word = rd_word | (WB'(1) << op_bit);
              ctl.wr  = 1'b1;
            end
          end
        end
        fbpa_pkg::MODE_INIT: begin
          ctl.init = 1'b1;
        end
        default: begin
          status_next = fbpa_pkg::ST_OK;
        end
      endcase
    end
  end

  fbpa_free_map #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .ROWS       (ROWS),
    .ROW_W      (ROW_W)
  ) u_map (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .rd_row      (rd_row),
    .wr_row      (op_row),
    .wr_word     (wr_word),
    .rd_word     (rd_word),
    .row_nonempty(row_nonempty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      status        <= status_next;
      block_address <= block_address_next;
    end
  end

endmodule

// File: design/fbpa_free_map.sv
// Free bitmap store: word memory with per-row stale marks and nonempty flags.
`timescale 1ns / 1ps

module fbpa_free_map #(
  parameter int BLOCK_COUNT = 64,
  parameter int ROWS = 2,
  parameter int ROW_W = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fbpa_pkg::map_ctl_t              ctl,
  input  logic [ROW_W-1:0]                rd_row,
  input  logic [ROW_W-1:0]                wr_row,
  input  logic [fbpa_pkg::WORD_BITS-1:0]  wr_word,
  output logic [fbpa_pkg::WORD_BITS-1:0]  rd_word,
  output logic [ROWS-1:0]                 row_nonempty
);

  localparam int WB = fbpa_pkg::WORD_BITS;

  logic [WB-1:0]    mem [ROWS];
  logic [WB-1:0]    rd_data;
  logic [ROWS-1:0]  stale;
  logic             stale_ones;
  logic             rd_stale;
  logic [ROW_W-1:0] rd_row_q;
  logic [WB-1:0]    fill;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_row] <= wr_word;
    end
    if (ctl.rd) begin
      rd_data  <= mem[rd_row];
      rd_stale <= stale[rd_row];
      rd_row_q <= rd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale        <= '1;
      stale_ones   <= 1'b0;
      row_nonempty <= '0;
    end else if (ctl.init) begin
      stale        <= '1;
      stale_ones   <= 1'b1;
      row_nonempty <= '1;
    end else if (ctl.wr) begin
      stale[wr_row]        <= 1'b0;
      row_nonempty[wr_row] <= |wr_word;
    end
  end

  // blocks past the pool end never read as free
  always_comb begin
    for (int j = 0; j < WB; j++) begin
      fill[j] = stale_ones && ((int'(rd_row_q) * WB + j) < BLOCK_COUNT);
    end
  end

  assign rd_word = rd_stale ? fill : rd_data;

endmodule
